[rtl/dtsp_pkg.sv]
// Shared types and constants of the display terminal stream parser.
package dtsp_pkg;

    // Result action codes.
    localparam logic [1:0] ACT_CHAR  = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_BEEP  = 2'd3;

    // Stream byte codes.
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] FORE_FIRST   = 8'h80;
    localparam logic [7:0] FORE_LAST    = 8'h8F;
    localparam logic [7:0] BACK_FIRST   = 8'h90;
    localparam logic [7:0] BACK_LAST    = 8'h9F;
    localparam logic [7:0] CODE_BEEP    = 8'hA0;
    localparam logic [7:0] CODE_PIXEL   = 8'hB0;
    localparam logic [7:0] CODE_CLEAR   = 8'hFF;

    // Pixel word that ends pixel mode.
    localparam logic [31:0] END_MARK = 32'hAA55AA55;

    // Palette indices after reset: white on black.
    localparam logic [3:0] FORE_RESET = 4'd15;
    localparam logic [3:0] BACK_RESET = 4'd0;

    // Result queue depth and derived widths.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_COUNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [6:0]  char_code;
        logic [3:0]  fore_index;
        logic [3:0]  back_index;
        logic [31:0] pixel_word;
        logic        beep_off;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [9:0]  cursor_x;
        logic [9:0]  cursor_y;
        logic [3:0]  fore_color;
        logic [3:0]  back_color;
        logic        pixel_mode;
        logic [1:0]  byte_count;
        logic [23:0] word_accum;
        logic        beep_flag;
    } t_state;

    typedef struct packed {
        logic [Q_COUNT_W-1:0] count;
        logic                 room_for_two;
    } t_qstat;

endpackage

[rtl/dtsp_in_if.sv]
// Input byte channel of the display terminal stream parser.
interface dtsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

[rtl/dtsp_out_if.sv]
// Drawing command channel of the display terminal stream parser.
interface dtsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [6:0]  char_code;
    logic [3:0]  fore_index;
    logic [3:0]  back_index;
    logic [31:0] pixel_word;
    logic        beep_off;
    logic        last;

    modport source (output valid, output action, output pos_x, output pos_y,
                    output char_code, output fore_index, output back_index,
                    output pixel_word, output beep_off, output last, input ready);
    modport sink   (input valid, input action, input pos_x, input pos_y,
                    input char_code, input fore_index, input back_index,
                    input pixel_word, input beep_off, input last, output ready);
endinterface

[rtl/dtsp_decode.sv]
// Combinational byte decoder: next parser state and up to two drawing commands.
module dtsp_decode #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int CHAR_HEIGHT   = 8,
    parameter int CHAR_WIDTH    = 8
) (
    input  dtsp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output dtsp_pkg::t_state  o_next,
    output logic [1:0]        o_num,
    output dtsp_pkg::t_result o_res0,
    output dtsp_pkg::t_result o_res1
);

    localparam logic [10:0] CW = 11'(CHAR_WIDTH);
    localparam logic [10:0] CH = 11'(CHAR_HEIGHT);
    localparam logic [10:0] SW = 11'(SCREEN_WIDTH);
    localparam logic [10:0] SH = 11'(SCREEN_HEIGHT);

    always_comb begin
        dtsp_pkg::t_result chr;
        logic [31:0]       word;
        logic [9:0]        cur_x;
        logic [9:0]        cur_y;
        logic [9:0]        x_adv;

        o_next = i_state;
        o_num  = 2'd0;
        o_res0 = '0;
        o_res1 = '0;
        chr    = '0;
        word   = {i_byte, i_state.word_accum};
        cur_x  = i_state.cursor_x;
        cur_y  = i_state.cursor_y;
        x_adv  = '0;

        if (i_state.pixel_mode) begin
            // Every byte is pixel data; the fourth one completes a word.
            if (i_state.byte_count != 2'd3) begin
                case (i_state.byte_count)
                    2'd0:    o_next.word_accum[7:0]   = i_state.word_accum[7:0] | i_byte;
                    2'd1:    o_next.word_accum[15:8]  = i_state.word_accum[15:8] | i_byte;
                    default: o_next.word_accum[23:16] = i_state.word_accum[23:16] | i_byte;
                endcase
                o_next.byte_count = i_state.byte_count + 2'd1;
            end else begin
                if (word != dtsp_pkg::END_MARK) begin
                    o_res0.action     = dtsp_pkg::ACT_PIXEL;
                    o_res0.pixel_word = word;
                    o_num             = 2'd1;
                end else begin
                    o_next.pixel_mode = 1'b0;
                end
                o_next.word_accum = '0;
                o_next.byte_count = 2'd0;
            end
        end else if (i_byte[7]) begin
            unique case (i_byte) inside
                [dtsp_pkg::FORE_FIRST:dtsp_pkg::FORE_LAST]: begin
                    o_next.fore_color = i_byte[3:0];
                end
                [dtsp_pkg::BACK_FIRST:dtsp_pkg::BACK_LAST]: begin
                    o_next.back_color = i_byte[3:0];
                end
                dtsp_pkg::CODE_BEEP: begin
                    o_next.beep_flag = 1'b1;
                    o_res0.action    = dtsp_pkg::ACT_BEEP;
                    o_num            = 2'd1;
                end
                dtsp_pkg::CODE_PIXEL: begin
                    o_next.pixel_mode = 1'b1;
                    o_next.word_accum = '0;
                    o_next.byte_count = 2'd0;
                end
                dtsp_pkg::CODE_CLEAR: begin
                    o_res0.action     = dtsp_pkg::ACT_CLEAR;
                    o_res0.beep_off   = 1'b1;
                    o_num             = 2'd1;
                    o_next.cursor_x   = '0;
                    o_next.cursor_y   = '0;
                    o_next.beep_flag  = 1'b0;
                    o_next.pixel_mode = 1'b0;
                end
                default: begin
                end
            endcase
        end else begin
            // The screen is cleared first when the current line would end at or beyond the bottom edge.
            if ({1'b0, cur_y} + CH >= SH) begin
                o_res0.action     = dtsp_pkg::ACT_CLEAR;
                o_num             = 2'd1;
                cur_x             = '0;
                cur_y             = '0;
                o_next.pixel_mode = 1'b0;
            end
            o_next.cursor_x = cur_x;
            o_next.cursor_y = cur_y;
            if (i_byte == dtsp_pkg::BYTE_NEWLINE) begin
                o_next.cursor_y = 10'({1'b0, cur_y} + CH);
                o_next.cursor_x = '0;
            end else begin
                chr.action     = dtsp_pkg::ACT_CHAR;
                chr.pos_x      = cur_x[8:0];
                chr.pos_y      = cur_y[8:0];
                chr.char_code  = i_byte[6:0];
                chr.fore_index = i_state.fore_color;
                chr.back_index = i_state.back_color;
                if (o_num == 2'd1) begin
                    o_res1 = chr;
                end else begin
                    o_res0 = chr;
                end
                o_num = o_num + 2'd1;
                x_adv = 10'({1'b0, cur_x} + CW);
                if ({1'b0, x_adv} >= SW - 11'd1) begin
                    o_next.cursor_x = '0;
                    o_next.cursor_y = 10'({1'b0, cur_y} + CH);
                end else begin
                    o_next.cursor_x = x_adv;
                end
            end
        end

        if (o_num == 2'd1) begin
            o_res0.last = 1'b1;
        end
        if (o_num == 2'd2) begin
            o_res1.last = 1'b1;
        end
    end

endmodule

[rtl/dtsp_outq.sv]
// Result queue: takes up to two commands per cycle and hands out one per word.
module dtsp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_num,
    input  dtsp_pkg::t_result i_res0,
    input  dtsp_pkg::t_result i_res1,
    input  logic              i_pop,
    output dtsp_pkg::t_result o_head,
    output dtsp_pkg::t_qstat  o_stat
);

    localparam int PW = dtsp_pkg::Q_PTR_W;
    localparam int CW = dtsp_pkg::Q_COUNT_W;

    dtsp_pkg::t_result r_mem [dtsp_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] r_rd;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          pop_go;

    assign pop_go  = i_pop && (r_count != '0);
    assign n_wr    = r_wr + PW'(i_push_num);
    assign n_rd    = r_rd + PW'(pop_go);
    assign n_count = r_count + CW'(i_push_num) - CW'(pop_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_res1;
        end
    end

    assign o_head              = r_mem[r_rd];
    assign o_stat.count        = r_count;
    assign o_stat.room_for_two = (r_count <= CW'(dtsp_pkg::Q_DEPTH - 2));

endmodule

[rtl/display_terminal_stream_parser.sv]
// Top level of the display terminal stream parser.
//
// The parser takes one stream byte per word on i_in and emits drawing
// commands (character draw, pixel word, clear screen, beep start) on o_out,
// one command per word. A byte is decoded in the cycle it is accepted: the
// parser state register and a four-entry result queue are updated at that
// edge, so a command is offered on o_out from the following cycle. A new byte
// can be taken every cycle as long as the queue has room for two commands;
// most bytes give at most one command, so the sustained rate is one byte per
// cycle while o_out keeps up; a text byte that forces a full-screen clear
// gives two commands. The output side drains one command per cycle while
// o_out.ready is high, so that side sets the rate when the stream
// is dense in such bytes. There is no clearing pass and no start-up delay.
module display_terminal_stream_parser #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int CHAR_HEIGHT   = 8,
    parameter int CHAR_WIDTH    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtsp_in_if.sink    i_in,
    dtsp_out_if.source o_out
);

    // Parser state: cursor, palette indices, beep flag and pixel assembler.
    dtsp_pkg::t_state  r_state;
    dtsp_pkg::t_state  n_state;

    // Outputs of the byte decoder.
    logic [1:0]        dec_num;
    dtsp_pkg::t_result dec_res0;
    dtsp_pkg::t_result dec_res1;

    // Queue status and head command.
    dtsp_pkg::t_qstat  q_stat;
    dtsp_pkg::t_result q_head;

    logic              in_accept;

    // A byte is only taken when the queue can hold both of the commands that
    // it might produce, so no command is ever dropped.
    assign i_in.ready = q_stat.room_for_two;
    assign in_accept  = i_in.valid && i_in.ready;

    dtsp_decode #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CHAR_HEIGHT   (CHAR_HEIGHT),
        .CHAR_WIDTH    (CHAR_WIDTH)
    ) u_decode (
        .i_state (r_state),
        .i_byte  (i_in.byte_in),
        .o_next  (n_state),
        .o_num   (dec_num),
        .o_res0  (dec_res0),
        .o_res1  (dec_res1)
    );

    // The state only moves on an accepted byte; reset gives white on black,
    // the cursor at home, text mode and the beep off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cursor_x   <= '0;
            r_state.cursor_y   <= '0;
            r_state.fore_color <= dtsp_pkg::FORE_RESET;
            r_state.back_color <= dtsp_pkg::BACK_RESET;
            r_state.pixel_mode <= 1'b0;
            r_state.byte_count <= '0;
            r_state.word_accum <= '0;
            r_state.beep_flag  <= 1'b0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    dtsp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (in_accept ? dec_num : 2'd0),
        .i_res0     (dec_res0),
        .i_res1     (dec_res1),
        .i_pop      (o_out.ready),
        .o_head     (q_head),
        .o_stat     (q_stat)
    );

    // The head of the queue is presented whenever the queue is not empty.
    assign o_out.valid      = (q_stat.count != '0);
    assign o_out.action     = q_head.action;
    assign o_out.pos_x      = q_head.pos_x;
    assign o_out.pos_y      = q_head.pos_y;
    assign o_out.char_code  = q_head.char_code;
    assign o_out.fore_index = q_head.fore_index;
    assign o_out.back_index = q_head.back_index;
    assign o_out.pixel_word = q_head.pixel_word;
    assign o_out.beep_off   = q_head.beep_off;
    assign o_out.last       = q_head.last;

`ifndef SYNTHESIS
    // The cursor column always stays left of the wrap point.
    a_cursor_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state.cursor_x) < SCREEN_WIDTH - 1)
        else $error("cursor column beyond wrap point");

    // Outside pixel mode the word assembler is empty.
    a_assembler_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.pixel_mode |-> (r_state.byte_count == 2'd0 && r_state.word_accum == '0))
        else $error("pixel assembler busy outside pixel mode");

    // A clear code in text mode homes the cursor and silences the beep.
    a_clear_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_state.pixel_mode && i_in.byte_in == dtsp_pkg::CODE_CLEAR)
        |=> (r_state.cursor_x == '0 && r_state.cursor_y == '0 && !r_state.beep_flag))
        else $error("clear code did not home the cursor");

    // The queue never holds more commands than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_stat.count) <= dtsp_pkg::Q_DEPTH)
        else $error("result queue overflow");

    // An accepted byte that produces a command makes the queue non-empty.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && dec_num != 2'd0) |=> o_out.valid)
        else $error("accepted command not offered");
`endif

endmodule
